// ===== rtl/vrt_pkg.sv =====
// Package: shared constants and types for the voxel ray traversal block.
package vrt_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int BW = 40;
	localparam logic [BW-1:0] BND_INF = {BW{1'b1}};

	typedef enum logic [2:0] {
		ST_QUERY  = 3'd0,
		ST_SOLID  = 3'd1,
		ST_LEFT   = 3'd2,
		ST_REACH  = 3'd3,
		ST_IGNORE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_OUT
	} state_t;

	// Divider control between sequencer and divider
	typedef struct packed {
		logic        start;
		logic [19:0] mag;
	} div_req_t;
endpackage

// ===== rtl/vrt_div.sv =====
// Module: radix-2 restoring divider computing 2^(2F) / mag, saturated to 40 bits.
module vrt_div import vrt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  div_req_t      req,
	output logic          done,
	output logic [BW-1:0] quo
);
	localparam int NB = 2*FRAC_BITS + 1;
	localparam int CW = $clog2(NB + 1);
	localparam int QW = (NB > BW) ? NB : BW + 1;

	logic [NB-1:0] num_q;
	logic [NB-1:0] quo_q;
	logic [19:0]   rem_q;
	logic [19:0]   mag_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [20:0]   rem_sh;
	logic [21:0]   diff;
	logic [QW-1:0] quo_ext;

	assign rem_sh = {rem_q, num_q[NB-1]};
	assign diff   = {1'b0, rem_sh} - {2'b0, mag_q};

	// One quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= NB'(1) << (2*FRAC_BITS);
			rem_q <= '0;
			quo_q <= '0;
			mag_q <= req.mag;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!diff[21]) begin
				rem_q <= diff[19:0];
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[19:0];
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end
	end

	// Saturate (only for a small mag when F is 20 or more)
	always_comb begin
		quo_ext = QW'(quo_q);
		if (quo_ext > QW'(BND_INF)) quo = BND_INF;
		else quo = quo_ext[BW-1:0];
	end
endmodule

// ===== rtl/voxel_ray_traversal_3d.sv =====
// Top level: 3D Amanatides-Woo grid walk with a shared serial divider.
//
// Input channel (in_valid/in_stall): kind 0 starts a ray from origin, dir
// and reach; kind 1 answers the last cell query with cell_present and
// cell_solid. Every input transfer produces exactly one result on the
// output channel (out_valid/out_stall).
// A start transfer runs a serial division on the shared divider for each
// axis with a nonzero direction component and a multiply step for every
// axis; a zero component skips its division. An answer transfer goes
// straight to the output step. Either way the block takes no new item until
// its result has been loaded into the output register.
// The output register holds the result while out_stall is high; the block
// takes the next item meanwhile but holds in_stall high before loading its
// result until the pending result has been transferred.
// Reset clears the walk: the block is idle, last axis none, and an answer
// received before any start returns status ignored.
module voxel_ray_traversal_3d import vrt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [19:0] dir_x,
	input  logic signed [19:0] dir_y,
	input  logic signed [19:0] dir_z,
	input  logic [30:0]        reach,
	input  logic               cell_present,
	input  logic               cell_solid,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [15:0] cell_x,
	output logic signed [15:0] cell_y,
	output logic signed [15:0] cell_z,
	output logic signed [1:0]  normal_x,
	output logic signed [1:0]  normal_y,
	output logic signed [1:0]  normal_z
);
	localparam logic [BW-1:0] ONE = BW'(1) << FRAC_BITS;
	localparam int PW = BW + FRAC_BITS;

	state_t state_q, state_d;

	logic               walking_q;
	logic [15:0]        cell_q   [3];
	logic [2:0]         neg_q;
	logic [BW-1:0]      nb_q     [3];
	logic [BW-1:0]      dl_q     [3];
	logic [1:0]         last_q;
	logic [30:0]        reach_q;
	logic [FRAC_BITS-1:0] org_q  [3];
	logic [19:0]        mag_q    [3];
	logic [1:0]         ax_q;
	logic               kind_q, pres_q, solid_q;

	div_req_t      dreq;
	logic          ddone;
	logic [BW-1:0] dquo;
	logic [BW-1:0] span;
	logic [PW-1:0] prod;
	logic          accept;
	logic [1:0]    sel;
	logic [BW-1:0] sum;
	logic [2:0]    st_d;
	logic [15:0]   ocell_d [3];
	logic [1:0]    onorm_d [3];

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	vrt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quo(dquo)
	);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		dreq.start = 1'b0;
		dreq.mag   = mag_q[ax_q];
		case (state_q)
			S_IDLE: if (accept) state_d = kind ? S_OUT : S_DIV;
			S_DIV: begin
				if (mag_q[ax_q] == '0) state_d = S_MUL;
				else if (ddone) state_d = S_MUL;
			end
			S_MUL: state_d = (ax_q == 2'd2) ? S_OUT : S_DIV;
			S_OUT: if (!out_valid || !out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_MUL && ax_q != 2'd2 && mag_q[ax_q + 2'd1] != '0)
			dreq.start = 1'b1;
		if (state_q == S_IDLE && accept && !kind && dir_x != '0)
			dreq.start = 1'b1;
		if (state_q == S_IDLE) dreq.mag = dir_x[19] ? 20'(-dir_x) : dir_x;
		else if (state_q == S_MUL) dreq.mag = mag_q[ax_q + 2'd1];
	end

	// Boundary multiply for the axis being set up
	always_comb begin
		logic [BW-1:0] dl;
		logic [BW-1:0] frac;
		dl   = (mag_q[ax_q] == '0) ? BND_INF : dquo;
		frac = BW'(org_q[ax_q]);
		span = neg_q[ax_q] ? frac : (ONE - frac);
		prod = PW'(dl) * PW'(span);
	end

	// Step choice and result for a start or an answer
	always_comb begin
		logic [BW:0] s;
		if (nb_q[0] < nb_q[1]) sel = (nb_q[0] < nb_q[2]) ? 2'd0 : 2'd2;
		else                   sel = (nb_q[1] < nb_q[2]) ? 2'd1 : 2'd2;
		s   = {1'b0, nb_q[sel]} + {1'b0, dl_q[sel]};
		sum = (s > {1'b0, BND_INF}) ? BND_INF : s[BW-1:0];
		for (int i = 0; i < 3; i++) begin
			ocell_d[i] = cell_q[i];
			onorm_d[i] = 2'b00;
		end
		if (!kind_q) begin
			st_d = ST_QUERY;
		end else if (!walking_q) begin
			st_d = ST_IGNORE;
			for (int i = 0; i < 3; i++) ocell_d[i] = '0;
		end else if (!pres_q || solid_q) begin
			st_d = !pres_q ? ST_LEFT : ST_SOLID;
			if (last_q != 2'd3) onorm_d[last_q] = neg_q[last_q] ? 2'b01 : 2'b11;
		end else begin
			ocell_d[sel] = neg_q[sel] ? cell_q[sel] - 16'd1 : cell_q[sel] + 16'd1;
			st_d = (nb_q[sel] > BW'(reach_q)) ? ST_REACH : ST_QUERY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			walking_q <= 1'b0;
			last_q    <= 2'd3;
			out_valid <= 1'b0;
			ax_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) ax_q <= '0;
				S_MUL: ax_q <= ax_q + 2'd1;
				S_OUT: if (!out_valid || !out_stall) begin
					if (!kind_q) begin
						walking_q <= 1'b1;
						last_q    <= 2'd3;
					end else if (walking_q) begin
						if (!pres_q || solid_q) walking_q <= 1'b0;
						else begin
							last_q <= sel;
							if (st_d == ST_REACH) walking_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				kind_q  <= kind;
				pres_q  <= cell_present;
				solid_q <= cell_solid;
				if (!kind) begin
					org_q[0] <= origin_x[FRAC_BITS-1:0];
					org_q[1] <= origin_y[FRAC_BITS-1:0];
					org_q[2] <= origin_z[FRAC_BITS-1:0];
					mag_q[0] <= dir_x[19] ? 20'(-dir_x) : dir_x;
					mag_q[1] <= dir_y[19] ? 20'(-dir_y) : dir_y;
					mag_q[2] <= dir_z[19] ? 20'(-dir_z) : dir_z;
					neg_q    <= {!(dir_z > 0), !(dir_y > 0), !(dir_x > 0)};
					reach_q  <= reach;
					cell_q[0] <= 16'(origin_x >>> FRAC_BITS);
					cell_q[1] <= 16'(origin_y >>> FRAC_BITS);
					cell_q[2] <= 16'(origin_z >>> FRAC_BITS);
				end
			end
			S_MUL: begin
				dl_q[ax_q] <= (mag_q[ax_q] == '0) ? BND_INF : dquo;
				nb_q[ax_q] <= (mag_q[ax_q] == '0 || dquo == BND_INF) ? BND_INF
				              : prod[BW+FRAC_BITS-1:FRAC_BITS];
			end
			S_OUT: if (!out_valid || !out_stall) begin
				status   <= st_d;
				cell_x   <= ocell_d[0];
				cell_y   <= ocell_d[1];
				cell_z   <= ocell_d[2];
				normal_x <= onorm_d[0];
				normal_y <= onorm_d[1];
				normal_z <= onorm_d[2];
				if (kind_q && walking_q && pres_q && !solid_q) begin
					cell_q[sel] <= ocell_d[sel];
					nb_q[sel]   <= sum;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== tb/vrt_checker.sv =====
// Checker: predicts voxel walk results from observed input transfers and compares outputs.
`timescale 1ns / 100ps
module vrt_checker import vrt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [19:0] dir_x,
	input  logic signed [19:0] dir_y,
	input  logic signed [19:0] dir_z,
	input  logic [30:0]        reach,
	input  logic               cell_present,
	input  logic               cell_solid,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         status,
	input  logic signed [15:0] cell_x,
	input  logic signed [15:0] cell_y,
	input  logic signed [15:0] cell_z,
	input  logic signed [1:0]  normal_x,
	input  logic signed [1:0]  normal_y,
	input  logic signed [1:0]  normal_z,
	output int                 errors,
	output int                 pending
);
	localparam int F = FRAC_BITS_DEF;

	typedef struct packed {
		status_t            st;
		logic signed [15:0] cx, cy, cz;
		logic signed [1:0]  nx, ny, nz;
	} walk_result_t;

	walk_result_t result_q[$];

	// walk state
	logic           walking;
	logic [15:0]    cur_cell[3];
	logic           step_neg[3];
	logic [BW-1:0]  bnd_next[3];
	logic [BW-1:0]  bnd_delta[3];
	logic [1:0]     last_ax;
	logic [31:0]    walk_reach;

	assign pending = result_q.size();

	// load one axis of a new ray
	task automatic load_axis(input int a, input logic signed [31:0] org,
			input logic signed [19:0] dir);
		logic [F-1:0] frac;
		logic [63:0]  mag, delta, span;
		frac = org[F-1:0];
		cur_cell[a] = org[F+15:F];
		step_neg[a] = !(dir > 0);
		mag = (dir < 0) ? -64'(dir) : 64'(dir);
		if (mag == 0)
			delta = BND_INF;
		else begin
			delta = (64'd1 << (2*F)) / mag;
			if (delta > BND_INF) delta = BND_INF;
		end
		bnd_delta[a] = delta[BW-1:0];
		span = step_neg[a] ? 64'(frac) : (64'd1 << F) - 64'(frac);
		if (delta == BND_INF)
			bnd_next[a] = BND_INF;
		else
			bnd_next[a] = BW'((delta * span) >> F);
	endtask

	// work out the result of one accepted input transfer
	task automatic predict_walk(output walk_result_t r);
		int ax;
		logic [BW-1:0] t;
		logic [BW:0]   s;
		r = '0;
		if (!kind) begin
			load_axis(0, origin_x, dir_x);
			load_axis(1, origin_y, dir_y);
			load_axis(2, origin_z, dir_z);
			walk_reach = {1'b0, reach};
			last_ax = 2'd3;
			walking = 1'b1;
			r.st = ST_QUERY;
			r.cx = cur_cell[0]; r.cy = cur_cell[1]; r.cz = cur_cell[2];
		end else if (!walking) begin
			r.st = ST_IGNORE;
		end else if (!cell_present || cell_solid) begin
			r.st = !cell_present ? ST_LEFT : ST_SOLID;
			r.cx = cur_cell[0]; r.cy = cur_cell[1]; r.cz = cur_cell[2];
			case (last_ax)
				2'd0: r.nx = step_neg[0] ? 2'sd1 : -2'sd1;
				2'd1: r.ny = step_neg[1] ? 2'sd1 : -2'sd1;
				2'd2: r.nz = step_neg[2] ? 2'sd1 : -2'sd1;
				default: ;
			endcase
			walking = 1'b0;
		end else begin
			if (bnd_next[0] < bnd_next[1])
				ax = (bnd_next[0] < bnd_next[2]) ? 0 : 2;
			else
				ax = (bnd_next[1] < bnd_next[2]) ? 1 : 2;
			cur_cell[ax] = step_neg[ax] ? cur_cell[ax] - 16'd1 : cur_cell[ax] + 16'd1;
			t = bnd_next[ax];
			s = {1'b0, bnd_next[ax]} + {1'b0, bnd_delta[ax]};
			bnd_next[ax] = (s > {1'b0, BND_INF}) ? BND_INF : s[BW-1:0];
			last_ax = 2'(ax);
			r.cx = cur_cell[0]; r.cy = cur_cell[1]; r.cz = cur_cell[2];
			if ({24'd0, t} > {32'd0, walk_reach}) begin
				r.st = ST_REACH;
				walking = 1'b0;
			end else
				r.st = ST_QUERY;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		walk_result_t want, got;
		if (!arst_n) begin
			walking = 1'b0;
			last_ax = 2'd3;
			walk_reach = '0;
			for (int a = 0; a < 3; a++) begin
				cur_cell[a] = '0; step_neg[a] = 1'b0;
				bnd_next[a] = '0; bnd_delta[a] = '0;
			end
			result_q.delete();
			errors <= 0;
		end else begin
			// output side first: a result cannot come out in the cycle its item goes in
			if (out_valid && !out_stall) begin
				got = '{status_t'(status), cell_x, cell_y, cell_z,
					normal_x, normal_y, normal_z};
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					errors <= errors + 1;
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_walk(want);
				result_q.push_back(want);
			end
		end
	end
endmodule

// ===== tb/tb.sv =====
// Testbench top: drives rays and cell answers into the voxel walker and gives the verdict.
`timescale 1ns / 100ps
module tb;
	logic clk = 1'b0, arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
	logic kind = 1'b0;
	logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [19:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [30:0] reach = '0;
	logic cell_present = 1'b0, cell_solid = 1'b0;
	logic [2:0] status;
	logic signed [15:0] cell_x, cell_y, cell_z;
	logic signed [1:0] normal_x, normal_y, normal_z;
	int errors, pending;
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_off = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	voxel_ray_traversal_3d dut (.*);
	vrt_checker chk (.*);

	// receiver: random stall, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// one input transfer; waits until accepted, valid stays up for the next item
	task automatic send_item(input logic k, input logic signed [31:0] ox, oy, oz,
			input logic signed [19:0] dx, dy, dz, input logic [30:0] rch,
			input logic pres, input logic sol);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1; kind <= k;
		origin_x <= ox; origin_y <= oy; origin_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		reach <= rch; cell_present <= pres; cell_solid <= sol;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_start(input logic signed [31:0] ox, oy, oz,
			input logic signed [19:0] dx, dy, dz, input logic [30:0] rch);
		send_item(1'b0, ox, oy, oz, dx, dy, dz, rch, 1'($urandom), 1'($urandom));
	endtask

	task automatic send_answer(input logic pres, input logic sol);
		send_item(1'b1, $urandom, $urandom, $urandom, 20'($urandom), 20'($urandom),
			20'($urandom), 31'($urandom), pres, sol);
	endtask

	// a random direction component: small half the time, else full-range, extreme or zero
	function automatic logic signed [19:0] rand_dir();
		case ($urandom_range(5))
			0: return 20'sd0;
			1: return 20'($urandom);
			2: return $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
			default: return 20'($signed($urandom_range(131072)) - 65536);
		endcase
	endfunction

	task automatic random_walk();
		int steps;
		logic [30:0] rch;
		rch = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(20 << 16));
		send_start($urandom, $urandom, $urandom, rand_dir(), rand_dir(), rand_dir(), rch);
		steps = $urandom_range(12);
		repeat (steps) send_answer(1'b1, 1'b0);
		case ($urandom_range(3))
			0: send_answer(1'b0, 1'($urandom));
			1: send_answer(1'b1, 1'b1);
			default: ;
		endcase
	endtask

	int sent;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: answer while idle, extremes, ties, zero direction, solid/left priority
		send_answer(1'b1, 1'b0);
		send_start(32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 20'sh7FFFF, 20'sh80000, 20'sh0,
			31'h7FFFFFFF);
		send_answer(1'b1, 1'b0);
		send_answer(1'b1, 1'b0);
		send_answer(1'b0, 1'b1);
		send_answer(1'b1, 1'b0);
		send_start(32'sh00008000, 32'sh00008000, 32'sh00008000, 20'sh10000, 20'sh10000,
			20'sh10000, 31'h00030000);
		repeat (4) send_answer(1'b1, 1'b0);
		send_answer(1'b1, 1'b1);
		send_start('0, '0, '0, '0, '0, '0, '0);
		send_answer(1'b1, 1'b0);
		send_answer(1'b1, 1'b0);
		send_start(32'shFFFF0000, 32'sh0000FFFF, 32'sh7FFF0000, -20'sh00001, 20'sh00001,
			20'shF0000, 31'h0);
		send_answer(1'b1, 1'b0);
		send_start('1, '1, '1, 20'sh80000, 20'sh80000, 20'sh80000, 31'h7FFFFFFF);
		send_start('0, '0, '0, 20'sh10000, 20'sh0, 20'sh0, 31'h7FFFFFFF);
		send_answer(1'b1, 1'b0);
		send_answer(1'b0, 1'b0);
		// random phases with changing idle mix
		send_idle_pct = 19; recv_idle_pct = 49;
		sent = 0;
		while (sent < 360) begin random_walk(); sent += 8; end
		send_idle_pct = 49; recv_idle_pct = 19;
		while (sent < 720) begin random_walk(); sent += 8; end
		send_idle_pct = 0; recv_idle_pct = 0;
		// long hold-off while items keep coming
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (6) random_walk();
		join
		while (sent < 1080) begin random_walk(); sent += 8; end
		if ($urandom_range(1)) send_answer(1'($urandom), 1'($urandom));
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("** voxel_ray_traversal_3d: PASSED **");
		else
			$display("** voxel_ray_traversal_3d: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** voxel_ray_traversal_3d: FAILED **");
		$finish;
	end
endmodule
